// ===== rtl/cfpp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpp_pkg: shared types, constants and CRC functions of the frame parser
// Holds the frame layout constants, the configuration register indexes, the
// controller/datapath command and status structs and the CRC-16 helpers.
// ----------------------------------------------------------------------------
package cfpp_pkg;

  localparam int MaxPayload = 64;
  localparam int MaxFrame   = 77;

  // Frame layout: byte positions counted from the first start mark.
  localparam logic [6:0] PosCommand = 7'd3;
  localparam logic [6:0] PosSeqHi   = 7'd4;
  localparam logic [6:0] PosSeqLo   = 7'd5;
  localparam logic [6:0] PosFlags   = 7'd6;
  localparam logic [6:0] PosLenHi   = 7'd7;
  localparam logic [6:0] PosLenLo   = 7'd8;
  localparam logic [6:0] PosHcrcHi  = 7'd9;
  localparam logic [6:0] PosHcrcLo  = 7'd10;
  localparam logic [6:0] PosPayload = 7'd11;
  localparam logic [6:0] PosHdrFirst = 7'd2;

  // Configuration register indexes.
  localparam logic [2:0] CfgMarkFirst  = 3'd0;
  localparam logic [2:0] CfgMarkSecond = 3'd1;
  localparam logic [2:0] CfgPoly       = 3'd2;
  localparam logic [2:0] CfgInit       = 3'd3;
  localparam logic [2:0] CfgReflIn     = 3'd4;
  localparam logic [2:0] CfgReflOut    = 3'd5;
  localparam logic [2:0] CfgXorOut     = 3'd6;

  // Result kinds.
  localparam logic [1:0] KindFrame    = 2'd0;
  localparam logic [1:0] KindCrcError = 2'd1;
  localparam logic [1:0] KindOverflow = 2'd2;

  localparam logic [15:0] EmptyPayloadCrc = 16'hFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start_frame;
    logic       store_byte;
    logic       load_event;
    logic [1:0] event_kind;
    logic       emit_rd;
    logic       emit_wr;
  } cfpp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic first_hit;
    logic second_hit;
    logic too_large;
    logic frame_done;
    logic crc_ok;
    logic len_zero;
    logic emit_last;
    logic out_free;
  } cfpp_sts_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [15:0] rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15-i];
    end
    return r;
  endfunction

  // One byte through the CRC-16 register, most significant bit first unless the input is reflected.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly, input logic refl);
    logic [15:0] c;
    logic [7:0]  d;
    d = refl ? rev8(b) : b;
    c = crc ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_finish(input logic [15:0] crc, input logic refl,
                                             input logic [15:0] xor_out);
    logic [15:0] c;
    c = refl ? rev16(crc) : crc;
    return c ^ xor_out;
  endfunction

endpackage

// ===== rtl/crc_framed_packet_parser_unit.sv =====
// ----------------------------------------------------------------------------
// crc_framed_packet_parser_unit: start-mark, length and CRC-16 frame parser
// Each received byte is taken while collecting; the completing byte is
// followed by a check state, then one result per payload byte (a memory
// read, then an output load), or one error/empty-frame result.
// Throughput: one byte per cycle while collecting; no input during the burst.
// Reset: synchronous, active low; hunting state and reset register values.
// ----------------------------------------------------------------------------
module crc_framed_packet_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // command, sequence_res, frame_flags,
                                  // payload_length, payload_byte, zero pad
  output logic [2:0]  out_tuser,  // event_kind, has_byte
  output logic        out_tlast
);

  cfpp_pkg::cfpp_cmd_t cmd;
  cfpp_pkg::cfpp_sts_t sts;

  cfpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfpp_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/cfpp_dpath.sv =====
// ----------------------------------------------------------------------------
// cfpp_dpath: frame parser datapath
// Configuration registers, byte counter, header fields, running CRCs, the
// payload memory and the result output register.
// ----------------------------------------------------------------------------
module cfpp_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_wdata,
  input  logic [7:0]           in_byte,
  input  cfpp_pkg::cfpp_cmd_t  cmd,
  output cfpp_pkg::cfpp_sts_t  sts,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [47:0]          out_tdata,  // command, sequence_res, frame_flags,
                                           // payload_length, payload_byte, pad
  output logic [2:0]           out_tuser,  // event_kind, has_byte
  output logic                 out_tlast
);

  // Configuration registers.
  logic [7:0]  mark1_r, mark2_r;
  logic [15:0] poly_r, init_r, xor_r;
  logic        refl_in_r, refl_out_r;

  // Frame state.
  logic [6:0]  count_r;
  logic [7:0]  command_r, flags_r, len_hi_r;
  logic [15:0] seq_r, hcrc_r, pcrc_r, hrun_r, prun_r;
  logic [6:0]  len_r;
  logic [5:0]  ptr_r;
  logic [7:0]  rd_data_r;
  logic [7:0]  pay_mem [cfpp_pkg::MaxPayload];

  // Output register.
  logic        out_valid_r;
  logic [1:0]  o_kind_r;
  logic [7:0]  o_cmd_r, o_flags_r, o_byte_r;
  logic [15:0] o_seq_r;
  logic [6:0]  o_len_r;
  logic        o_has_r, o_last_r;

  logic [15:0] len_full;
  logic        in_payload;
  logic [6:0]  pay_idx;
  logic        out_free;

  assign len_full   = {len_hi_r, in_byte};
  assign in_payload = (count_r >= cfpp_pkg::PosPayload) &&
                      (count_r < cfpp_pkg::PosPayload + len_r);
  assign pay_idx    = count_r - cfpp_pkg::PosPayload;
  assign out_free   = !out_valid_r || out_tready;

  // Status towards the controller.
  always_comb begin
    sts.first_hit  = (in_byte == mark1_r);
    sts.second_hit = (in_byte == mark2_r);
    sts.too_large  = (count_r == cfpp_pkg::PosLenLo) &&
                     (len_full > 16'(cfpp_pkg::MaxPayload));
    sts.frame_done = (count_r >= cfpp_pkg::PosPayload) &&
                     (count_r == 7'd12 + len_r);
    sts.crc_ok     = (hcrc_r == cfpp_pkg::crc_finish(hrun_r, refl_out_r, xor_r)) &&
                     (pcrc_r == ((len_r == 7'd0) ? cfpp_pkg::EmptyPayloadCrc :
                                 cfpp_pkg::crc_finish(prun_r, refl_out_r, xor_r)));
    sts.len_zero   = (len_r == 7'd0);
    sts.emit_last  = ({1'b0, ptr_r} + 7'd1 == len_r);
    sts.out_free   = out_free;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark1_r    <= 8'hAA;
      mark2_r    <= 8'h55;
      poly_r     <= 16'h1021;
      init_r     <= 16'hFFFF;
      refl_in_r  <= 1'b0;
      refl_out_r <= 1'b0;
      xor_r      <= 16'h0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfpp_pkg::CfgMarkFirst:  mark1_r    <= cfg_wdata[7:0];
        cfpp_pkg::CfgMarkSecond: mark2_r    <= cfg_wdata[7:0];
        cfpp_pkg::CfgPoly:       poly_r     <= cfg_wdata;
        cfpp_pkg::CfgInit:       init_r     <= cfg_wdata;
        cfpp_pkg::CfgReflIn:     refl_in_r  <= cfg_wdata[0];
        cfpp_pkg::CfgReflOut:    refl_out_r <= cfg_wdata[0];
        cfpp_pkg::CfgXorOut:     xor_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Byte counter and emit pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 7'd0;
      ptr_r   <= 6'd0;
    end else begin
      if (cmd.start_frame) begin
        count_r <= 7'd2;
        ptr_r   <= 6'd0;
      end else if (cmd.store_byte) begin
        count_r <= count_r + 7'd1;
      end
      if (cmd.emit_wr && out_free) begin
        ptr_r <= ptr_r + 6'd1;
      end
    end
  end

  // Header fields, CRC fields and running CRCs.
  always_ff @(posedge clk) begin
    if (cmd.start_frame) begin
      hrun_r <= init_r;
      prun_r <= init_r;
    end else if (cmd.store_byte) begin
      if (count_r >= cfpp_pkg::PosHdrFirst && count_r <= cfpp_pkg::PosLenLo) begin
        hrun_r <= cfpp_pkg::crc_feed(hrun_r, in_byte, poly_r, refl_in_r);
      end
      if (in_payload) begin
        prun_r <= cfpp_pkg::crc_feed(prun_r, in_byte, poly_r, refl_in_r);
      end
      if (count_r >= cfpp_pkg::PosPayload) begin
        pcrc_r <= {pcrc_r[7:0], in_byte};
      end
      unique case (count_r)
        cfpp_pkg::PosCommand: command_r     <= in_byte;
        cfpp_pkg::PosSeqHi:   seq_r[15:8]   <= in_byte;
        cfpp_pkg::PosSeqLo:   seq_r[7:0]    <= in_byte;
        cfpp_pkg::PosFlags:   flags_r       <= in_byte;
        cfpp_pkg::PosLenHi:   len_hi_r      <= in_byte;
        cfpp_pkg::PosLenLo:   len_r         <= len_full[6:0];
        cfpp_pkg::PosHcrcHi:  hcrc_r[15:8]  <= in_byte;
        cfpp_pkg::PosHcrcLo:  hcrc_r[7:0]   <= in_byte;
        default: ;
      endcase
    end
  end

  // Payload memory: written while collecting, read one byte per result.
  always_ff @(posedge clk) begin
    if (cmd.store_byte && in_payload) begin
      pay_mem[pay_idx[5:0]] <= in_byte;
    end
    if (cmd.emit_rd) begin
      rd_data_r <= pay_mem[ptr_r];
    end
  end

  // Result output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free && (cmd.load_event || cmd.emit_wr)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && cmd.emit_wr) begin
      o_kind_r  <= cpp_kind_frame();
      o_cmd_r   <= command_r;
      o_seq_r   <= seq_r;
      o_flags_r <= flags_r;
      o_len_r   <= len_r;
      o_byte_r  <= rd_data_r;
      o_has_r   <= 1'b1;
      o_last_r  <= sts.emit_last;
    end else if (out_free && cmd.load_event) begin
      // An empty valid frame carries its header fields; errors carry zeros.
      o_kind_r  <= cmd.event_kind;
      o_cmd_r   <= (cmd.event_kind == cfpp_pkg::KindFrame) ? command_r : 8'h00;
      o_seq_r   <= (cmd.event_kind == cfpp_pkg::KindFrame) ? seq_r : 16'h0000;
      o_flags_r <= (cmd.event_kind == cfpp_pkg::KindFrame) ? flags_r : 8'h00;
      o_len_r   <= 7'd0;
      o_byte_r  <= 8'h00;
      o_has_r   <= 1'b0;
      o_last_r  <= 1'b1;
    end
  end

  function automatic logic [1:0] cpp_kind_frame();
    return cfpp_pkg::KindFrame;
  endfunction

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, o_byte_r, o_len_r, o_flags_r, o_seq_r, o_cmd_r};
  assign out_tuser  = {o_has_r, o_kind_r};
  assign out_tlast  = o_last_r;

  // The byte counter never passes the largest frame.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 7'(cfpp_pkg::MaxFrame))
    else $error("byte counter beyond frame size");

  // The output register holds its result while the sink stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(o_byte_r) && $stable(o_last_r))
    else $error("result changed while stalled");

  // A payload result is only produced while the length is non-zero.
  a_emit_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_wr |-> len_r != 7'd0)
    else $error("payload emitted for empty frame");

endmodule

// ===== rtl/cfpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfpp_ctrl: frame parser controller
// Hunts for the start marks, steps through frame collection, the CRC check
// and the payload result burst, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module cfpp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  cfpp_pkg::cfpp_sts_t  sts,
  output cfpp_pkg::cfpp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_HUNT0   = 7'b0000001,
    ST_HUNT1   = 7'b0000010,
    ST_BODY    = 7'b0000100,
    ST_CHECK   = 7'b0001000,
    ST_OVF     = 7'b0010000,
    ST_EMIT_RD = 7'b0100000,
    ST_EMIT_WR = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_tready = (state_r == ST_HUNT0) || (state_r == ST_HUNT1) ||
                     (state_r == ST_BODY);
  assign in_fire   = in_tvalid && in_tready;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_HUNT0: begin
        if (in_fire && sts.first_hit) state_nxt = ST_HUNT1;
      end
      ST_HUNT1: begin
        if (in_fire) begin
          priority if (sts.second_hit) begin
            cmd.start_frame = 1'b1;
            state_nxt       = ST_BODY;
          end else if (!sts.first_hit) begin
            state_nxt = ST_HUNT0;
          end else begin
            state_nxt = ST_HUNT1;
          end
        end
      end
      ST_BODY: begin
        if (in_fire) begin
          cmd.store_byte = 1'b1;
          priority if (sts.too_large) state_nxt = ST_OVF;
          else if (sts.frame_done) state_nxt = ST_CHECK;
          else state_nxt = ST_BODY;
        end
      end
      ST_OVF: begin
        cmd.load_event = 1'b1;
        cmd.event_kind = cfpp_pkg::KindOverflow;
        if (sts.out_free) state_nxt = ST_HUNT0;
      end
      ST_CHECK: begin
        priority if (!sts.crc_ok) begin
          cmd.load_event = 1'b1;
          cmd.event_kind = cfpp_pkg::KindCrcError;
          if (sts.out_free) state_nxt = ST_HUNT0;
        end else if (sts.len_zero) begin
          cmd.load_event = 1'b1;
          cmd.event_kind = cfpp_pkg::KindFrame;
          if (sts.out_free) state_nxt = ST_HUNT0;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        cmd.emit_wr = 1'b1;
        if (sts.out_free) state_nxt = sts.emit_last ? ST_HUNT0 : ST_EMIT_RD;
      end
      default: state_nxt = ST_HUNT0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT0;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A length error and frame completion never come from the same byte.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BODY |-> !(sts.too_large && sts.frame_done))
    else $error("length error and completion together");

  // The byte that completes a frame leads to the CRC check.
  a_done_check: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BODY && in_fire && sts.frame_done && !sts.too_large
      |=> state_r == ST_CHECK)
    else $error("completed frame not checked");

  // The last payload transfer ends the burst.
  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT_WR && sts.out_free && sts.emit_last |=> state_r == ST_HUNT0)
    else $error("burst did not end on last byte");

endmodule

// ===== bench/crc_framed_packet_parser_unit_test.sv =====
// ----------------------------------------------------------------------------
// crc_framed_packet_parser_unit_test: self-checking bench of the frame parser
// Streams received bytes into the parser and checks every result transfer
// against a cycle-free model of the hunt, store and CRC-16 checks. A short
// directed table is followed by random frames under several CRC and start
// mark settings, with random idling on both sides of the block in the first two.
// ----------------------------------------------------------------------------
module crc_framed_packet_parser_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  cmd;
    logic [15:0] seq;
    logic [7:0]  flags;
    logic [6:0]  len;
    logic [7:0]  pbyte;
    logic        has;
    logic        last;
  } frame_event_t;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    logic [1:0] kind;
  } rx_item_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  crc_framed_packet_parser_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Model copy of the registers.
  logic [7:0]  mark_first, mark_second;
  logic [15:0] poly, crc_init, xor_out;
  logic        refl_in, refl_out;

  // Model copy of the parser state.
  logic [1:0]  phase;
  int unsigned count, total;
  logic [7:0]  store [cfpp_pkg::MaxFrame];
  logic [15:0] hdr_crc, pay_crc;

  rx_item_t     tx_bytes[$];
  frame_event_t pending_events[$];
  int unsigned  send_idle_pct, recv_idle_pct;
  int unsigned  err_cnt, frames_sent, events_seen;

  // The typed tag of the byte in flight, kept beside the data.
  rx_item_t in_flight;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Byte-wise CRC-16 advance under the current settings.
  function automatic logic [15:0] crc_advance(logic [15:0] c, logic [7:0] b);
    logic [7:0] d;
    for (int i = 0; i < 8; i++) d[i] = refl_in ? b[7-i] : b[i];
    c = c ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
    return c;
  endfunction

  function automatic logic [15:0] crc_close(logic [15:0] c);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) r[i] = refl_out ? c[15-i] : c[i];
    return r ^ xor_out;
  endfunction

  function automatic logic [15:0] store_be16(int unsigned i);
    return {store[i], store[i+1]};
  endfunction

  // A random byte that matches neither start mark.
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == mark_first || b == mark_second);
    return b;
  endfunction

  function automatic void rearm_hunt();
    phase = 2'd0;
    count = 0;
    total = 0;
    hdr_crc = crc_init;
    pay_crc = crc_init;
  endfunction

  function automatic void post_event(logic [1:0] kind);
    frame_event_t e;
    e = '0;
    e.kind = kind;
    e.last = 1'b1;
    pending_events.push_back(e);
  endfunction

  // Final checks once the whole frame is stored.
  function automatic void finish_frame();
    int unsigned len;
    logic [15:0] got;
    frame_event_t e;
    len = store_be16(cfpp_pkg::PosLenHi);
    got = (len == 0) ? cfpp_pkg::EmptyPayloadCrc : crc_close(pay_crc);
    if (store_be16(cfpp_pkg::PosHcrcHi) != crc_close(hdr_crc) ||
        store_be16(cfpp_pkg::PosPayload + len) != got) begin
      post_event(cfpp_pkg::KindCrcError);
    end else begin
      e = '0;
      e.kind = cfpp_pkg::KindFrame;
      e.cmd = store[cfpp_pkg::PosCommand];
      e.seq = store_be16(cfpp_pkg::PosSeqHi);
      e.flags = store[cfpp_pkg::PosFlags];
      e.len = 7'(len);
      if (len == 0) begin
        e.last = 1'b1;
        pending_events.push_back(e);
      end
      for (int i = 0; i < len; i++) begin
        e.pbyte = store[cfpp_pkg::PosPayload + i];
        e.has = 1'b1;
        e.last = (i + 1 == len);
        pending_events.push_back(e);
      end
    end
    rearm_hunt();
  endfunction

  // One accepted byte through the model.
  function automatic void parse_byte(logic [7:0] b);
    int unsigned idx;
    if (phase == 2'd0) begin
      if (b == mark_first) begin
        store[0] = b;
        count = 1;
        phase = 2'd1;
      end
    end else if (phase == 2'd1) begin
      if (b == mark_second) begin
        store[1] = b;
        count = 2;
        phase = 2'd2;
        hdr_crc = crc_init;
        pay_crc = crc_init;
      end else if (b == mark_first) begin
        store[0] = b;
        count = 1;
      end else begin
        rearm_hunt();
      end
    end else if (count >= cfpp_pkg::MaxFrame) begin
      post_event(cfpp_pkg::KindOverflow);
      rearm_hunt();
    end else begin
      idx = count;
      store[idx] = b;
      count = idx + 1;
      if (idx >= 2 && idx <= 8) hdr_crc = crc_advance(hdr_crc, b);
      if (total != 0 && idx >= 11 && idx + 2 < total) pay_crc = crc_advance(pay_crc, b);
      if (count == 9) begin
        if (store_be16(cfpp_pkg::PosLenHi) > cfpp_pkg::MaxPayload) begin
          post_event(cfpp_pkg::KindOverflow);
          rearm_hunt();
          return;
        end
        total = 13 + store_be16(cfpp_pkg::PosLenHi);
      end
      if (total != 0 && count >= total) finish_frame();
    end
  endfunction

  // Sender: hold a byte until it is taken, idle at random between bytes.
  always @(posedge clk) begin
    rx_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = tx_bytes.pop_front();
        in_tdata <= it.data;
        in_flight <= it;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stalls.
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Prediction on every accepted byte; typed rows replace the model's result.
  always @(posedge clk) begin
    int unsigned before_n;
    if (rst_n && in_tvalid && in_tready) begin
      before_n = pending_events.size();
      parse_byte(in_tdata);
      if (in_flight.typed) begin
        while (pending_events.size() > before_n) void'(pending_events.pop_back());
        post_event(in_flight.kind);
      end
    end
  end

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    frame_event_t e;
    if (rst_n && out_tvalid && out_tready) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        $error("unexpected result transfer, tdata %h tuser %h", out_tdata, out_tuser);
        err_cnt++;
      end else begin
        e = pending_events.pop_front();
        if (out_tuser[1:0] != e.kind) begin
          $error("event_kind: expected %0d, got %0d", e.kind, out_tuser[1:0]); err_cnt++;
        end
        if (out_tdata[7:0] != e.cmd) begin
          $error("command: expected %h, got %h", e.cmd, out_tdata[7:0]); err_cnt++;
        end
        if (out_tdata[23:8] != e.seq) begin
          $error("sequence_res: expected %h, got %h", e.seq, out_tdata[23:8]); err_cnt++;
        end
        if (out_tdata[31:24] != e.flags) begin
          $error("frame_flags: expected %h, got %h", e.flags, out_tdata[31:24]); err_cnt++;
        end
        if (out_tdata[38:32] != e.len) begin
          $error("payload_length: expected %0d, got %0d", e.len, out_tdata[38:32]); err_cnt++;
        end
        if (out_tdata[46:39] != e.pbyte) begin
          $error("payload_byte: expected %h, got %h", e.pbyte, out_tdata[46:39]); err_cnt++;
        end
        if (out_tuser[2] != e.has) begin
          $error("has_byte: expected %0d, got %0d", e.has, out_tuser[2]); err_cnt++;
        end
        if (out_tlast != e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_tlast); err_cnt++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      cfpp_pkg::CfgMarkFirst:  mark_first = val[7:0];
      cfpp_pkg::CfgMarkSecond: mark_second = val[7:0];
      cfpp_pkg::CfgPoly:       poly = val;
      cfpp_pkg::CfgInit:       crc_init = val;
      cfpp_pkg::CfgReflIn:     refl_in = val[0];
      cfpp_pkg::CfgReflOut:    refl_out = val[0];
      cfpp_pkg::CfgXorOut:     xor_out = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_byte(logic [7:0] b, logic typed = 1'b0,
                           logic [1:0] kind = cfpp_pkg::KindFrame);
    rx_item_t it;
    it.data = b;
    it.typed = typed;
    it.kind = kind;
    tx_bytes.push_back(it);
  endtask

  // Wait for the stream to drain and the block to settle.
  task automatic drain();
    do @(posedge clk); while (tx_bytes.size() != 0 || in_tvalid || pending_events.size() != 0);
    repeat (200) @(posedge clk);
  endtask

  // Queue one random frame, mostly well formed, sometimes broken.
  task automatic queue_frame(inout int unsigned n_bytes);
    logic [7:0]  hdr [7];
    logic [15:0] c, pc;
    logic [7:0]  pay [$];
    int unsigned pick, len;
    pick = $urandom_range(19);
    len = (pick < 2) ? 0 : (pick == 2) ? cfpp_pkg::MaxPayload : $urandom_range(1, 8);
    for (int i = 0; i < 5; i++) hdr[i] = 8'($urandom);
    hdr[5] = (pick == 3) ? 8'($urandom_range(255)) : 8'h00;
    hdr[6] = (pick == 3 && hdr[5] == 0) ? 8'($urandom_range(65, 255)) : 8'(len);
    push_byte(mark_first);
    push_byte(mark_second);
    c = crc_init;
    for (int i = 0; i < 7; i++) begin
      push_byte(hdr[i]);
      c = crc_advance(c, hdr[i]);
    end
    n_bytes += 9;
    frames_sent++;
    if (pick == 3) return;
    c = crc_close(c);
    if ($urandom_range(7) == 0) c ^= 16'h1 << $urandom_range(15);
    push_byte(c[15:8]);
    push_byte(c[7:0]);
    pc = crc_init;
    for (int i = 0; i < len; i++) begin
      pay.push_back(8'($urandom));
      push_byte(pay[i]);
      pc = crc_advance(pc, pay[i]);
    end
    pc = (len == 0) ? cfpp_pkg::EmptyPayloadCrc : crc_close(pc);
    if ($urandom_range(7) == 0) pc ^= 16'h1 << $urandom_range(15);
    push_byte(pc[15:8]);
    push_byte(pc[7:0]);
    n_bytes += 4 + len;
  endtask

  task automatic random_phase(int unsigned target);
    int unsigned n_bytes;
    n_bytes = 0;
    while (n_bytes < target) begin
      // Noise and broken starts between frames.
      repeat ($urandom_range(3)) begin
        push_byte(noise_byte());
        n_bytes++;
      end
      if ($urandom_range(5) == 0) begin
        push_byte(mark_first);
        push_byte(noise_byte());
        n_bytes += 2;
      end
      queue_frame(n_bytes);
    end
    drain();
  endtask

  // Directed table: noise, a repeated first mark, an oversized length and
  // an empty frame with a bad header CRC.
  localparam int DirRows = 25;
  localparam logic [10:0] DirTable [DirRows] = '{
    {8'h00, 1'b0, cfpp_pkg::KindFrame}, {8'hFF, 1'b0, cfpp_pkg::KindFrame},
    {8'hAA, 1'b0, cfpp_pkg::KindFrame}, {8'hAA, 1'b0, cfpp_pkg::KindFrame},
    {8'h55, 1'b0, cfpp_pkg::KindFrame},
    {8'h01, 1'b0, cfpp_pkg::KindFrame}, {8'h10, 1'b0, cfpp_pkg::KindFrame},
    {8'h12, 1'b0, cfpp_pkg::KindFrame},
    {8'h34, 1'b0, cfpp_pkg::KindFrame}, {8'h80, 1'b0, cfpp_pkg::KindFrame},
    {8'h00, 1'b0, cfpp_pkg::KindFrame},
    {8'h41, 1'b1, cfpp_pkg::KindOverflow},
    {8'hAA, 1'b0, cfpp_pkg::KindFrame}, {8'h55, 1'b0, cfpp_pkg::KindFrame},
    {8'h01, 1'b0, cfpp_pkg::KindFrame},
    {8'h02, 1'b0, cfpp_pkg::KindFrame}, {8'h00, 1'b0, cfpp_pkg::KindFrame},
    {8'h03, 1'b0, cfpp_pkg::KindFrame},
    {8'h04, 1'b0, cfpp_pkg::KindFrame}, {8'h00, 1'b0, cfpp_pkg::KindFrame},
    {8'h00, 1'b0, cfpp_pkg::KindFrame},
    {8'h00, 1'b0, cfpp_pkg::KindFrame}, {8'h00, 1'b0, cfpp_pkg::KindFrame},
    {8'hFF, 1'b0, cfpp_pkg::KindFrame},
    {8'hFF, 1'b1, cfpp_pkg::KindCrcError}
  };

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = cfpp_pkg::CfgMarkFirst;
    cfg_wdata = '0;
    in_tdata = '0;
    in_flight = '0;
    err_cnt = 0;
    frames_sent = 0;
    events_seen = 0;
    mark_first = 8'hAA;
    mark_second = 8'h55;
    poly = 16'h1021;
    crc_init = 16'hFFFF;
    refl_in = 1'b0;
    refl_out = 1'b0;
    xor_out = 16'h0000;
    rearm_hunt();
    send_idle_pct = 28;
    recv_idle_pct = 80;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under reset settings.
    for (int i = 0; i < DirRows; i++) begin
      push_byte(DirTable[i][10:3], DirTable[i][2], DirTable[i][1:0]);
    end
    drain();
    random_phase(70);

    // Extreme settings, sender idling more than the receiver.
    send_idle_pct = 80;
    recv_idle_pct = 28;
    write_reg(cfpp_pkg::CfgMarkFirst, 16'h0000);
    write_reg(cfpp_pkg::CfgMarkSecond, 16'h00FF);
    write_reg(cfpp_pkg::CfgPoly, 16'hFFFF);
    write_reg(cfpp_pkg::CfgInit, 16'h0000);
    write_reg(cfpp_pkg::CfgReflIn, 16'h0001);
    write_reg(cfpp_pkg::CfgReflOut, 16'h0001);
    write_reg(cfpp_pkg::CfgXorOut, 16'hFFFF);
    random_phase(80);

    // Both marks equal, reflected CRC-16, no idling from here on.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(cfpp_pkg::CfgMarkFirst, 16'h007E);
    write_reg(cfpp_pkg::CfgMarkSecond, 16'h007E);
    write_reg(cfpp_pkg::CfgPoly, 16'h8005);
    write_reg(cfpp_pkg::CfgXorOut, 16'h0000);
    random_phase(80);

    // Random polynomial and start value, plain bit order.
    write_reg(cfpp_pkg::CfgMarkFirst, 16'h00AA);
    write_reg(cfpp_pkg::CfgMarkSecond, 16'h0055);
    write_reg(cfpp_pkg::CfgPoly, 16'($urandom));
    write_reg(cfpp_pkg::CfgInit, 16'($urandom));
    write_reg(cfpp_pkg::CfgReflIn, 16'h0000);
    write_reg(cfpp_pkg::CfgReflOut, 16'h0000);
    write_reg(cfpp_pkg::CfgXorOut, 16'($urandom));
    random_phase(80);

    $display("Covered %0d random frames and %0d result transfers over four settings,",
             frames_sent, events_seen);
    $display("including repeated and equal start marks, oversized lengths and CRC errors.");
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cfpp_pkg.sv
rtl/cfpp_dpath.sv
rtl/cfpp_ctrl.sv
rtl/crc_framed_packet_parser_unit.sv
bench/crc_framed_packet_parser_unit_test.sv
